@@ hdl/daie_pkg.sv @@
// Shared definitions for the dynamic array instruction engine: field widths,
// instruction and error codes, and the command/status structs between the
// controller and the datapath. No dependencies.
`default_nettype none

package daie_pkg;

	// Parameter defaults
	localparam int NUM_ARRAYS_DEF = 8;
	localparam int CAPACITY_DEF   = 64;

	// Fixed field widths
	localparam int TYPE_W = 4;
	localparam int ID_W   = 3;
	localparam int IDX_W  = 16;
	localparam int VAL_W  = 64;
	localparam int ERR_W  = 2;
	// Compare width: one bit above an index or a length
	localparam int CMP_W  = IDX_W + 1;

	// Instruction codes
	typedef enum logic [TYPE_W-1:0] {
		OP_CLEAR  = 4'd0,
		OP_GET    = 4'd1,
		OP_SET    = 4'd2,
		OP_SIZE   = 4'd3,
		OP_EMPTY  = 4'd4,
		OP_FILL   = 4'd5,
		OP_RESIZE = 4'd6,
		OP_ERASE  = 4'd7,
		OP_INSERT = 4'd8,
		OP_PUSH   = 4'd9,
		OP_POP    = 4'd10,
		OP_FRONT  = 4'd11,
		OP_BACK   = 4'd12
	} op_t;

	// Error codes
	typedef enum logic [ERR_W-1:0] {
		ERR_OK    = 2'd0,
		ERR_INDEX = 2'd1,
		ERR_EMPTY = 2'd2,
		ERR_FULL  = 2'd3
	} err_t;

	// New length written to the length store
	typedef enum logic [1:0] {
		LS_ZERO = 2'd0,
		LS_NLEN = 2'd1,
		LS_DEC  = 2'd2,
		LS_INC  = 2'd3
	} len_src_t;

	// Element read position
	typedef enum logic [1:0] {
		RS_IDX  = 2'd0,
		RS_ZERO = 2'd1,
		RS_LAST = 2'd2
	} rd_src_t;

	// Element write position for single writes of the request value
	typedef enum logic {
		WS_IDX = 1'b0,
		WS_LEN = 1'b1
	} wr_src_t;

	// Result value source
	typedef enum logic [1:0] {
		RV_ZERO  = 2'd0,
		RV_LEN   = 2'd1,
		RV_EMPTY = 2'd2,
		RV_RDATA = 2'd3
	} res_sel_t;

	// Controller to datapath
	typedef struct packed {
		logic     take;
		logic     len_we;
		len_src_t len_src;
		logic     rd_en;
		rd_src_t  rd_src;
		logic     wr_en;
		wr_src_t  wr_src;
		logic     fill_init;
		logic     fill_zero;
		logic     fill_run;
		logic     shift_init;
		logic     shift_up;
		logic     shift_run;
		logic     res_load;
		res_sel_t res_sel;
		err_t     res_err;
		logic     out_load;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		op_t  op;
		logic op_known;
		logic arr_bad;
		logic len_zero;
		logic idx_lt_len;
		logic idx_gt_len;
		logic len_full;
		logic nlen_gt_cap;
		logic nlen_gt_len;
		logic fill_last;
		logic shift_done;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

@@ hdl/daie_ctrl.sv @@
// Controller state machine of the dynamic array instruction engine.
// Depends on daie_pkg; drives daie_pkg::cmd_t, reads daie_pkg::sts_t.
`default_nettype none

module daie_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire daie_pkg::sts_t sts,
	output daie_pkg::cmd_t     cmd
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_LEN   = 7'b0000010,
		S_RD    = 7'b0000100,
		S_FILL  = 7'b0001000,
		S_SHIFT = 7'b0010000,
		S_INS   = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// A new request is taken only between instructions
	assign in_stall = (state_q != S_IDLE);

	// Next state and commands
	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take  = 1'b1;
					state_nxt = S_LEN;
				end
			end
			// length is read back: decide the instruction
			S_LEN: begin
				cmd.res_load = 1'b1;
				cmd.res_sel  = daie_pkg::RV_ZERO;
				cmd.res_err  = daie_pkg::ERR_OK;
				state_nxt    = S_DONE;
				if (sts.arr_bad) begin
					cmd.res_err = sts.op_known ? daie_pkg::ERR_INDEX : daie_pkg::ERR_OK;
				end else begin
					unique case (sts.op)
						daie_pkg::OP_CLEAR: begin
							cmd.len_we  = 1'b1;
							cmd.len_src = daie_pkg::LS_ZERO;
						end
						daie_pkg::OP_GET: begin
							if (sts.idx_lt_len) begin
								cmd.rd_en    = 1'b1;
								cmd.rd_src   = daie_pkg::RS_IDX;
								cmd.res_load = 1'b0;
								state_nxt    = S_RD;
							end else begin
								cmd.res_err = daie_pkg::ERR_INDEX;
							end
						end
						daie_pkg::OP_SET: begin
							if (sts.idx_lt_len) begin
								cmd.wr_en  = 1'b1;
								cmd.wr_src = daie_pkg::WS_IDX;
							end else begin
								cmd.res_err = daie_pkg::ERR_INDEX;
							end
						end
						daie_pkg::OP_SIZE: begin
							cmd.res_sel = daie_pkg::RV_LEN;
						end
						daie_pkg::OP_EMPTY: begin
							cmd.res_sel = daie_pkg::RV_EMPTY;
						end
						daie_pkg::OP_FILL: begin
							if (!sts.len_zero) begin
								cmd.fill_init = 1'b1;
								cmd.fill_zero = 1'b0;
								state_nxt     = S_FILL;
							end
						end
						daie_pkg::OP_RESIZE: begin
							if (sts.nlen_gt_cap) begin
								cmd.res_err = daie_pkg::ERR_FULL;
							end else begin
								cmd.len_we  = 1'b1;
								cmd.len_src = daie_pkg::LS_NLEN;
								if (sts.nlen_gt_len) begin
									cmd.fill_init = 1'b1;
									cmd.fill_zero = 1'b1;
									state_nxt     = S_FILL;
								end
							end
						end
						daie_pkg::OP_ERASE: begin
							if (!sts.idx_lt_len) begin
								cmd.res_err = daie_pkg::ERR_INDEX;
							end else begin
								cmd.len_we     = 1'b1;
								cmd.len_src    = daie_pkg::LS_DEC;
								cmd.shift_init = 1'b1;
								cmd.shift_up   = 1'b1;
								state_nxt      = S_SHIFT;
							end
						end
						daie_pkg::OP_INSERT: begin
							if (sts.idx_gt_len) begin
								cmd.res_err = daie_pkg::ERR_INDEX;
							end else if (sts.len_full) begin
								cmd.res_err = daie_pkg::ERR_FULL;
							end else begin
								cmd.len_we     = 1'b1;
								cmd.len_src    = daie_pkg::LS_INC;
								cmd.shift_init = 1'b1;
								cmd.shift_up   = 1'b0;
								state_nxt      = S_SHIFT;
							end
						end
						daie_pkg::OP_PUSH: begin
							if (sts.len_full) begin
								cmd.res_err = daie_pkg::ERR_FULL;
							end else begin
								cmd.wr_en   = 1'b1;
								cmd.wr_src  = daie_pkg::WS_LEN;
								cmd.len_we  = 1'b1;
								cmd.len_src = daie_pkg::LS_INC;
							end
						end
						daie_pkg::OP_POP: begin
							if (sts.len_zero) begin
								cmd.res_err = daie_pkg::ERR_EMPTY;
							end else begin
								cmd.rd_en    = 1'b1;
								cmd.rd_src   = daie_pkg::RS_LAST;
								cmd.len_we   = 1'b1;
								cmd.len_src  = daie_pkg::LS_DEC;
								cmd.res_load = 1'b0;
								state_nxt    = S_RD;
							end
						end
						daie_pkg::OP_FRONT: begin
							if (sts.len_zero) begin
								cmd.res_err = daie_pkg::ERR_EMPTY;
							end else begin
								cmd.rd_en    = 1'b1;
								cmd.rd_src   = daie_pkg::RS_ZERO;
								cmd.res_load = 1'b0;
								state_nxt    = S_RD;
							end
						end
						daie_pkg::OP_BACK: begin
							if (sts.len_zero) begin
								cmd.res_err = daie_pkg::ERR_EMPTY;
							end else begin
								cmd.rd_en    = 1'b1;
								cmd.rd_src   = daie_pkg::RS_LAST;
								cmd.res_load = 1'b0;
								state_nxt    = S_RD;
							end
						end
						// unused codes: no change, empty result
						default: begin
						end
					endcase
				end
			end
			// element read data is in
			S_RD: begin
				cmd.res_load = 1'b1;
				cmd.res_sel  = daie_pkg::RV_RDATA;
				cmd.res_err  = daie_pkg::ERR_OK;
				state_nxt    = S_DONE;
			end
			// one element written per cycle
			S_FILL: begin
				cmd.fill_run = 1'b1;
				if (sts.fill_last) begin
					state_nxt = S_DONE;
				end
			end
			// read/write pipelined element move
			S_SHIFT: begin
				cmd.shift_run = 1'b1;
				if (sts.shift_done) begin
					state_nxt = (sts.op == daie_pkg::OP_INSERT) ? S_INS : S_DONE;
				end
			end
			// drop the new word into the gap
			S_INS: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_src = daie_pkg::WS_IDX;
				state_nxt  = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ hdl/daie_dp.sv @@
// Datapath of the dynamic array instruction engine: request registers,
// length store, element memory, walk counters and the output register.
// Depends on daie_pkg; driven by daie_ctrl through daie_pkg::cmd_t.
`default_nettype none

module daie_dp #(
	parameter int NUM_ARRAYS = daie_pkg::NUM_ARRAYS_DEF,
	parameter int CAPACITY   = daie_pkg::CAPACITY_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire daie_pkg::cmd_t              cmd,
	output daie_pkg::sts_t                   sts,
	input  wire logic [daie_pkg::TYPE_W-1:0] req_type,
	input  wire logic [daie_pkg::ID_W-1:0]   array_id,
	input  wire logic [daie_pkg::IDX_W-1:0]  index,
	input  wire logic [daie_pkg::IDX_W-1:0]  new_length,
	input  wire logic [daie_pkg::VAL_W-1:0]  value,
	input  wire logic                        out_stall,
	output logic                             out_valid,
	output logic [daie_pkg::VAL_W-1:0]       result_value,
	output logic                             has_value,
	output logic [daie_pkg::ERR_W-1:0]       error_code
);

	localparam int DEPTH = NUM_ARRAYS * CAPACITY;
	localparam int MAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int AW    = (NUM_ARRAYS > 1) ? $clog2(NUM_ARRAYS) : 1;
	localparam int PW    = $clog2(CAPACITY);
	localparam int LW    = $clog2(CAPACITY + 1);
	localparam int XW    = daie_pkg::CMP_W;
	localparam int VW    = daie_pkg::VAL_W;

	// Request registers
	logic [daie_pkg::TYPE_W-1:0] req_type_q;
	logic [daie_pkg::ID_W-1:0]   array_id_q;
	logic [AW-1:0]               arr_ix_q;
	logic [daie_pkg::IDX_W-1:0]  index_q;
	logic [daie_pkg::IDX_W-1:0]  new_length_q;
	logic [VW-1:0]               value_q;

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			req_type_q   <= req_type;
			array_id_q   <= array_id;
			arr_ix_q     <= AW'(array_id);
			index_q      <= index;
			new_length_q <= new_length;
			value_q      <= value;
		end
	end

	// Length store: memory plus a valid bit per array; unwritten reads as zero
	logic [LW-1:0]         len_mem [NUM_ARRAYS];
	logic [NUM_ARRAYS-1:0] len_vld_q;
	logic [LW-1:0]         len_rd_s1;
	logic                  len_rv_s1;
	logic [LW-1:0]         len_cur;
	logic [LW-1:0]         len_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_vld_q <= '0;
			len_rv_s1 <= 1'b0;
		end else begin
			if (cmd.len_we) begin
				len_vld_q[arr_ix_q] <= 1'b1;
			end
			if (cmd.take) begin
				len_rv_s1 <= len_vld_q[AW'(array_id)];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.len_we) begin
			len_mem[arr_ix_q] <= len_wdata;
		end
		if (cmd.take) begin
			len_rd_s1 <= len_mem[AW'(array_id)];
		end
	end

	assign len_cur = len_rv_s1 ? len_rd_s1 : '0;

	always_comb begin
		unique case (cmd.len_src)
			daie_pkg::LS_ZERO: len_wdata = '0;
			daie_pkg::LS_NLEN: len_wdata = LW'(new_length_q);
			daie_pkg::LS_DEC:  len_wdata = len_cur - LW'(1);
			daie_pkg::LS_INC:  len_wdata = len_cur + LW'(1);
			default:           len_wdata = '0;
		endcase
	end

	// Compares on the current length
	logic [XW-1:0] idx_w;
	logic [XW-1:0] nlen_w;
	logic [XW-1:0] len_w;

	assign idx_w  = XW'(index_q);
	assign nlen_w = XW'(new_length_q);
	assign len_w  = XW'(len_cur);

	// Walk counters shared by fill and shift
	logic [PW-1:0] ptr_q;
	logic [PW-1:0] end_q;
	logic [VW-1:0] pattern_q;
	logic          shift_up_q;
	logic [LW-1:0] cnt_q;
	logic          pend_s1;
	logic [PW-1:0] dst_s1;
	logic          shift_rd;
	logic          shift_wr;

	assign shift_rd = cmd.shift_run && (cnt_q != '0);
	assign shift_wr = cmd.shift_run && pend_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			pend_s1 <= 1'b0;
		end else if (cmd.shift_init) begin
			cnt_q   <= cmd.shift_up ? LW'(len_w - idx_w - XW'(1)) : LW'(len_w - idx_w);
			pend_s1 <= 1'b0;
		end else if (cmd.shift_run) begin
			pend_s1 <= shift_rd;
			if (shift_rd) begin
				cnt_q <= cnt_q - LW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fill_init) begin
			ptr_q     <= cmd.fill_zero ? PW'(len_cur) : '0;
			end_q     <= cmd.fill_zero ? PW'(nlen_w - XW'(1)) : PW'(len_w - XW'(1));
			pattern_q <= cmd.fill_zero ? '0 : value_q;
		end else if (cmd.shift_init) begin
			ptr_q      <= cmd.shift_up ? PW'(idx_w + XW'(1)) : PW'(len_w - XW'(1));
			shift_up_q <= cmd.shift_up;
		end else if (cmd.fill_run) begin
			ptr_q <= ptr_q + PW'(1);
		end else if (shift_rd) begin
			ptr_q  <= shift_up_q ? ptr_q + PW'(1) : ptr_q - PW'(1);
			dst_s1 <= shift_up_q ? ptr_q - PW'(1) : ptr_q + PW'(1);
		end
	end

	// Element memory port selection
	logic [MAW-1:0] base;
	logic           mem_we;
	logic [PW-1:0]  wr_pos;
	logic [VW-1:0]  wr_data;
	logic           mem_re;
	logic [PW-1:0]  rd_pos;
	logic [VW-1:0]  rd_data_q;

	assign base   = MAW'(arr_ix_q) * MAW'(CAPACITY);
	assign mem_we = cmd.wr_en | cmd.fill_run | shift_wr;
	assign mem_re = cmd.rd_en | shift_rd;

	always_comb begin
		if (cmd.wr_en) begin
			wr_pos  = (cmd.wr_src == daie_pkg::WS_IDX) ? PW'(index_q) : PW'(len_cur);
			wr_data = value_q;
		end else if (cmd.fill_run) begin
			wr_pos  = ptr_q;
			wr_data = pattern_q;
		end else begin
			wr_pos  = dst_s1;
			wr_data = rd_data_q;
		end
	end

	always_comb begin
		if (cmd.rd_en) begin
			unique case (cmd.rd_src)
				daie_pkg::RS_IDX:  rd_pos = PW'(index_q);
				daie_pkg::RS_ZERO: rd_pos = '0;
				daie_pkg::RS_LAST: rd_pos = PW'(len_cur - LW'(1));
				default:           rd_pos = '0;
			endcase
		end else begin
			rd_pos = ptr_q;
		end
	end

	// Element memory, one write and one registered read per cycle
	logic [VW-1:0] elem_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			elem_mem[base + MAW'(wr_pos)] <= wr_data;
		end
		if (mem_re) begin
			rd_data_q <= elem_mem[base + MAW'(rd_pos)];
		end
	end

	// Result staging
	logic [VW-1:0] res_val_q;
	logic          res_hv_q;
	daie_pkg::err_t res_err_q;

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_hv_q  <= (cmd.res_sel != daie_pkg::RV_ZERO);
			res_err_q <= cmd.res_err;
			unique case (cmd.res_sel)
				daie_pkg::RV_ZERO:  res_val_q <= '0;
				daie_pkg::RV_LEN:   res_val_q <= VW'(len_cur);
				daie_pkg::RV_EMPTY: res_val_q <= VW'(len_cur == '0);
				daie_pkg::RV_RDATA: res_val_q <= rd_data_q;
				default:            res_val_q <= '0;
			endcase
		end
	end

	// Output register
	logic                       out_valid_q;
	logic [VW-1:0]              result_value_q;
	logic                       has_value_q;
	logic [daie_pkg::ERR_W-1:0] error_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result_value_q <= res_val_q;
			has_value_q    <= res_hv_q;
			error_code_q   <= res_err_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = result_value_q;
	assign has_value    = has_value_q;
	assign error_code   = error_code_q;

	// Status to the controller
	assign sts.op          = daie_pkg::op_t'(req_type_q);
	assign sts.op_known    = (req_type_q <= daie_pkg::TYPE_W'(daie_pkg::OP_BACK));
	assign sts.arr_bad     = (32'(array_id_q) >= NUM_ARRAYS);
	assign sts.len_zero    = (len_cur == '0);
	assign sts.idx_lt_len  = (idx_w < len_w);
	assign sts.idx_gt_len  = (idx_w > len_w);
	assign sts.len_full    = (len_w >= XW'(CAPACITY));
	assign sts.nlen_gt_cap = (nlen_w > XW'(CAPACITY));
	assign sts.nlen_gt_len = (nlen_w > len_w);
	assign sts.fill_last   = (ptr_q == end_q);
	assign sts.shift_done  = (cnt_q == '0) && !pend_s1;
	assign sts.out_free    = !out_valid_q || !out_stall;

endmodule

`default_nettype wire

@@ hdl/dynamic_array_instruction_engine_core.sv @@
// Top level of the dynamic array instruction engine: controller plus datapath.
// Depends on daie_pkg, daie_ctrl and daie_dp.
//
//   channel   direction  handshake            payload
//   request   in         in_valid / in_stall   req_type array_id index new_length value
//   result    out        out_valid / out_stall result_value has_value error_code
//
// One request at a time. Size, empty, clear, set, push, fill of an empty array, plain
// resize and error cases go from the length read to the result; get, pop, front, back
// read an element first. Fill and growing resize write one element per cycle; erase
// and insert move elements through the memory port, and insert then fills the gap.
// Lengths come out of reset at zero through per-array valid bits: no clearing pass.
// A stalled result is held in the output register; the next request is still taken.
`default_nettype none

module dynamic_array_instruction_engine_core #(
	parameter int NUM_ARRAYS = daie_pkg::NUM_ARRAYS_DEF,
	parameter int CAPACITY   = daie_pkg::CAPACITY_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [daie_pkg::TYPE_W-1:0] req_type,
	input  wire logic [daie_pkg::ID_W-1:0]   array_id,
	input  wire logic [daie_pkg::IDX_W-1:0]  index,
	input  wire logic [daie_pkg::IDX_W-1:0]  new_length,
	input  wire logic [daie_pkg::VAL_W-1:0]  value,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [daie_pkg::VAL_W-1:0]       result_value,
	output logic                             has_value,
	output logic [daie_pkg::ERR_W-1:0]       error_code
);

	daie_pkg::cmd_t cmd;
	daie_pkg::sts_t sts;

	daie_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	daie_dp #(
		.NUM_ARRAYS (NUM_ARRAYS),
		.CAPACITY   (CAPACITY)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.req_type     (req_type),
		.array_id     (array_id),
		.index        (index),
		.new_length   (new_length),
		.value        (value),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.result_value (result_value),
		.has_value    (has_value),
		.error_code   (error_code)
	);

`ifndef SYNTHESIS
	// an accepted request blocks the next one from being taken back to back
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request taken back to back");

	// a value-bearing result never carries an error
	a_value_no_error: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && has_value) |-> (error_code == daie_pkg::ERR_OK))
		else $error("result with value and error");

	// without a value the word is zero
	a_no_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !has_value) |-> (result_value == '0))
		else $error("result word not zero");

	// sequencing commands are exclusive
	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.take, cmd.fill_run, cmd.shift_run, cmd.out_load, cmd.res_load}))
		else $error("overlapping controller commands");
`endif

endmodule

`default_nettype wire

@@ dv/daie_array_checker.sv @@
// Result checker for the dynamic array instruction engine: watches both channels,
// predicts each result from its own copy of the arrays and compares in order.
// Depends on daie_pkg.
`timescale 1ns / 100ps

module daie_array_checker
	import daie_pkg::*;
#(
	parameter int NUM_ARRAYS = NUM_ARRAYS_DEF,
	parameter int CAPACITY   = CAPACITY_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [TYPE_W-1:0] req_type,
	input  logic [ID_W-1:0]   array_id,
	input  logic [IDX_W-1:0]  index,
	input  logic [IDX_W-1:0]  new_length,
	input  logic [VAL_W-1:0]  value,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [VAL_W-1:0]  result_value,
	input  logic              has_value,
	input  logic [ERR_W-1:0]  error_code,
	output int                fail_count,
	output int                pending
);

	typedef struct {
		logic [VAL_W-1:0] value;
		logic             has;
		logic [ERR_W-1:0] err;
	} array_result_t;

	// Own copy of the element store and the per-array lengths
	logic [VAL_W-1:0] element_copy [NUM_ARRAYS*CAPACITY];
	int unsigned      length_copy  [NUM_ARRAYS];
	array_result_t    expected_results [$];

	// Carry out one instruction on the copy and return what the block must answer
	function automatic array_result_t apply_instruction(
		input logic [TYPE_W-1:0] kind,
		input logic [ID_W-1:0]   arr,
		input logic [IDX_W-1:0]  idx,
		input logic [IDX_W-1:0]  nlen,
		input logic [VAL_W-1:0]  val
	);
		array_result_t r;
		int unsigned   len;
		int unsigned   base;
		int unsigned   i;
		r.value = '0;
		r.has   = 1'b0;
		r.err   = ERR_OK;
		if (arr >= NUM_ARRAYS) begin
			if (kind <= OP_BACK)
				r.err = ERR_INDEX;
			return r;
		end
		len  = length_copy[arr];
		base = arr * CAPACITY;
		case (kind)
			OP_CLEAR: length_copy[arr] = 0;
			OP_GET: begin
				if (idx < len) begin
					r.value = element_copy[base + idx];
					r.has   = 1'b1;
				end else
					r.err = ERR_INDEX;
			end
			OP_SET: begin
				if (idx < len)
					element_copy[base + idx] = val;
				else
					r.err = ERR_INDEX;
			end
			OP_SIZE: begin
				r.value = VAL_W'(len);
				r.has   = 1'b1;
			end
			OP_EMPTY: begin
				r.value = VAL_W'(len == 0);
				r.has   = 1'b1;
			end
			OP_FILL: begin
				for (i = 0; i < len; i++)
					element_copy[base + i] = val;
			end
			OP_RESIZE: begin
				if (nlen > CAPACITY)
					r.err = ERR_FULL;
				else begin
					// growing pads with zeros
					for (i = len; i < nlen; i++)
						element_copy[base + i] = '0;
					length_copy[arr] = 32'(nlen);
				end
			end
			OP_ERASE: begin
				if (idx >= len)
					r.err = ERR_INDEX;
				else begin
					for (i = idx; i + 1 < len; i++)
						element_copy[base + i] = element_copy[base + i + 1];
					length_copy[arr] = len - 1;
				end
			end
			OP_INSERT: begin
				// index range is checked ahead of capacity
				if (idx > len)
					r.err = ERR_INDEX;
				else if (len >= CAPACITY)
					r.err = ERR_FULL;
				else begin
					for (i = len; i > idx; i--)
						element_copy[base + i] = element_copy[base + i - 1];
					element_copy[base + idx] = val;
					length_copy[arr] = len + 1;
				end
			end
			OP_PUSH: begin
				if (len >= CAPACITY)
					r.err = ERR_FULL;
				else begin
					element_copy[base + len] = val;
					length_copy[arr] = len + 1;
				end
			end
			OP_POP: begin
				if (len == 0)
					r.err = ERR_EMPTY;
				else begin
					r.value = element_copy[base + len - 1];
					r.has   = 1'b1;
					length_copy[arr] = len - 1;
				end
			end
			OP_FRONT: begin
				if (len == 0)
					r.err = ERR_EMPTY;
				else begin
					r.value = element_copy[base];
					r.has   = 1'b1;
				end
			end
			OP_BACK: begin
				if (len == 0)
					r.err = ERR_EMPTY;
				else begin
					r.value = element_copy[base + len - 1];
					r.has   = 1'b1;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Compare taken results, then predict for a request taken at this edge
	always @(posedge clk or negedge arst_n) begin
		array_result_t exp;
		array_result_t pred;
		if (!arst_n) begin
			foreach (length_copy[a])
				length_copy[a] = 0;
			expected_results.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					$error("unexpected result: result_value %h has_value %b error_code %0d",
						result_value, has_value, error_code);
				end else begin
					exp = expected_results.pop_front();
					if (result_value !== exp.value) begin
						fail_count++;
						$error("result_value: expected %h, got %h", exp.value, result_value);
					end
					if (has_value !== exp.has) begin
						fail_count++;
						$error("has_value: expected %b, got %b", exp.has, has_value);
					end
					if (error_code !== exp.err) begin
						fail_count++;
						$error("error_code: expected %0d, got %0d", exp.err, error_code);
					end
				end
			end
			if (in_valid && !in_stall) begin
				pred = apply_instruction(req_type, array_id, index, new_length, value);
				expected_results = {expected_results, pred};
			end
			pending = expected_results.size();
		end
	end

endmodule

@@ dv/tb_top.sv @@
// Testbench top for the dynamic array instruction engine: clock, reset, request
// stimulus with random gaps and result stalls, and the verdict.
// Depends on daie_pkg, daie_array_checker and dynamic_array_instruction_engine_core.
`timescale 1ns / 100ps

module tb_top;
	import daie_pkg::*;

	localparam int NUM_ARRAYS   = NUM_ARRAYS_DEF;
	localparam int CAPACITY     = CAPACITY_DEF;
	localparam int RANDOM_ITEMS = 1625;
	localparam int DRAIN_LIMIT  = 20000;
	localparam int TAIL_CYCLES  = 150;
	localparam logic [TYPE_W-1:0] OP_UNUSED_FIRST = 4'd13;
	localparam logic [TYPE_W-1:0] OP_UNUSED_LAST  = 4'd15;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [TYPE_W-1:0] req_type;
	logic [ID_W-1:0]   array_id;
	logic [IDX_W-1:0]  index;
	logic [IDX_W-1:0]  new_length;
	logic [VAL_W-1:0]  value;
	logic              out_valid;
	logic              out_stall;
	logic [VAL_W-1:0]  result_value;
	logic              has_value;
	logic [ERR_W-1:0]  error_code;
	int                fail_count;
	int                pending;

	// Rough array lengths, only to aim indexes near the live range
	int unsigned fill_level [NUM_ARRAYS];
	int unsigned send_burst;
	int unsigned recv_burst;

	dynamic_array_instruction_engine_core #(
		.NUM_ARRAYS(NUM_ARRAYS),
		.CAPACITY  (CAPACITY)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.array_id    (array_id),
		.index       (index),
		.new_length  (new_length),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_value(result_value),
		.has_value   (has_value),
		.error_code  (error_code)
	);

	daie_array_checker #(
		.NUM_ARRAYS(NUM_ARRAYS),
		.CAPACITY  (CAPACITY)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.array_id    (array_id),
		.index       (index),
		.new_length  (new_length),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_value(result_value),
		.has_value   (has_value),
		.error_code  (error_code),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop in case a handshake hangs
	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

	// Idle cycles ahead of the next transfer, with runs of back-to-back traffic
	function automatic int unsigned draw_gap(ref int unsigned burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			burst = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 17);
	endfunction

	// Follow the lengths a request leaves behind
	function automatic void track_level(input logic [TYPE_W-1:0] kind,
		input logic [ID_W-1:0] arr, input logic [IDX_W-1:0] idx,
		input logic [IDX_W-1:0] nlen);
		int unsigned lvl;
		lvl = fill_level[arr];
		case (kind)
			OP_CLEAR:  fill_level[arr] = 0;
			OP_RESIZE: if (nlen <= CAPACITY) fill_level[arr] = 32'(nlen);
			OP_ERASE:  if (idx < lvl) fill_level[arr] = lvl - 1;
			OP_INSERT: if (idx <= lvl && lvl < CAPACITY) fill_level[arr] = lvl + 1;
			OP_PUSH:   if (lvl < CAPACITY) fill_level[arr] = lvl + 1;
			OP_POP:    if (lvl > 0) fill_level[arr] = lvl - 1;
			default: ;
		endcase
	endfunction

	// Present one request from a falling edge and hold it until it is taken
	task automatic send_request(input logic [TYPE_W-1:0] kind, input logic [ID_W-1:0] arr,
		input logic [IDX_W-1:0] idx, input logic [IDX_W-1:0] nlen,
		input logic [VAL_W-1:0] val);
		int unsigned gap;
		gap = draw_gap(send_burst);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   = 1'b1;
		req_type   = kind;
		array_id   = arr;
		index      = idx;
		new_length = nlen;
		value      = val;
		do @(posedge clk); while (in_stall);
		track_level(kind, arr, idx, nlen);
		@(negedge clk);
	endtask

	// Result side: random stall ahead of every result
	initial begin
		int unsigned hold;
		out_stall  = 1'b0;
		recv_burst = 0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			hold = draw_gap(recv_burst);
			if (hold > 0) begin
				out_stall = 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall = 1'b0;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// Request side and verdict
	initial begin
		logic [TYPE_W-1:0] kind;
		logic [ID_W-1:0]   arr;
		logic [IDX_W-1:0]  idx;
		logic [IDX_W-1:0]  nlen;
		logic [VAL_W-1:0]  val;
		int unsigned       lvl;
		int unsigned       pick;
		int unsigned       drained;

		arst_n     = 1'b0;
		in_valid   = 1'b0;
		req_type   = '0;
		array_id   = '0;
		index      = '0;
		new_length = '0;
		value      = '0;
		send_burst = 0;
		foreach (fill_level[a])
			fill_level[a] = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty array cases first
		send_request(OP_SIZE,   0, 0, 0, '0);
		send_request(OP_EMPTY,  0, 0, 0, '0);
		send_request(OP_POP,    0, 0, 0, '0);
		send_request(OP_FRONT,  0, 0, 0, '0);
		send_request(OP_BACK,   0, 0, 0, '0);
		send_request(OP_GET,    0, 0, 0, '0);
		send_request(OP_SET,    0, 0, 0, '1);
		send_request(OP_ERASE,  0, 0, 0, '0);
		send_request(OP_FILL,   0, 0, 0, '1);
		send_request(OP_CLEAR,  0, 0, 0, '0);
		// insert past the end, then at the end
		send_request(OP_INSERT, 0, 1, 0, '1);
		send_request(OP_INSERT, 0, 0, 0, '1);
		send_request(OP_PUSH,   0, 0, 0, '0);
		send_request(OP_FRONT,  0, 0, 0, '0);
		// full array: push, insert at the end, insert past the end, oversize resize
		send_request(OP_RESIZE, 7, 0, IDX_W'(CAPACITY), '0);
		send_request(OP_PUSH,   7, 0, 0, '1);
		send_request(OP_INSERT, 7, IDX_W'(CAPACITY), 0, '1);
		send_request(OP_INSERT, 7, IDX_W'(CAPACITY + 1), 0, '1);
		send_request(OP_RESIZE, 7, 0, IDX_W'(CAPACITY + 1), '0);
		send_request(OP_RESIZE, 7, 0, '1, '0);
		send_request(OP_GET,    7, IDX_W'(CAPACITY - 1), 0, '0);
		send_request(OP_GET,    7, '1, 0, '0);
		send_request(OP_FILL,   7, 0, 0, 64'hA5A5_5A5A_0F0F_F0F0);
		send_request(OP_ERASE,  7, 0, 0, '0);
		send_request(OP_BACK,   7, 0, 0, '0);
		for (int k = OP_UNUSED_FIRST; k <= OP_UNUSED_LAST; k++)
			send_request(TYPE_W'(k), 5, '1, '1, '1);

		// Random: mostly in-range indexes around the live length
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			arr  = ID_W'($urandom_range(0, NUM_ARRAYS - 1));
			lvl  = fill_level[arr];
			if      (pick < 22) kind = OP_PUSH;
			else if (pick < 34) kind = OP_INSERT;
			else if (pick < 44) kind = OP_SET;
			else if (pick < 56) kind = OP_GET;
			else if (pick < 64) kind = OP_ERASE;
			else if (pick < 72) kind = OP_POP;
			else if (pick < 75) kind = OP_FRONT;
			else if (pick < 78) kind = OP_BACK;
			else if (pick < 82) kind = OP_SIZE;
			else if (pick < 85) kind = OP_EMPTY;
			else if (pick < 88) kind = OP_FILL;
			else if (pick < 94) kind = OP_RESIZE;
			else if (pick < 97) kind = OP_CLEAR;
			else kind = TYPE_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));

			pick = $urandom_range(0, 9);
			if (pick < 7)
				idx = (lvl == 0) ? '0 :
					IDX_W'($urandom_range(0, (kind == OP_INSERT) ? lvl : lvl - 1));
			else if (pick < 9)
				idx = IDX_W'(lvl + $urandom_range(0, 2));
			else
				idx = IDX_W'($urandom());

			pick = $urandom_range(0, 9);
			if (pick < 7)
				nlen = IDX_W'($urandom_range(0, CAPACITY));
			else if (pick < 8)
				nlen = IDX_W'(CAPACITY + $urandom_range(1, 3));
			else
				nlen = IDX_W'($urandom());

			pick = $urandom_range(0, 9);
			if (pick == 0)
				val = '0;
			else if (pick == 1)
				val = '1;
			else
				val = {$urandom(), $urandom()};

			send_request(kind, arr, idx, nlen, val);
		end
		in_valid = 1'b0;

		// Drain, then give a late stray result time to show
		drained = 0;
		while (pending != 0 && drained < DRAIN_LIMIT) begin
			@(negedge clk);
			drained++;
		end
		repeat (TAIL_CYCLES) @(negedge clk);

		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
